@@ src/leb_pkg.sv @@
// Shared types and constants for the line edit buffer.
package leb_pkg;

	localparam int CHAR_W      = 8;
	localparam int CMD_W       = 3;
	localparam int MAX_OUT_W   = 7;
	localparam logic [MAX_OUT_W-1:0] MAX_OUT_RESET = 7'd64;

	// Decoded key commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_LEFT      = 3'd1,
		CMD_RIGHT     = 3'd2,
		CMD_HOME      = 3'd3,
		CMD_END       = 3'd4,
		CMD_BACKSPACE = 3'd5,
		CMD_DELETE    = 3'd6,
		CMD_ENTER     = 3'd7
	} leb_cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS_PUT,
		ST_DEL_FIN,
		ST_EM_RD,
		ST_EM_OUT,
		ST_TERM
	} leb_state_t;

	// Output status from the sequencer to the stream port.
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [MAX_OUT_W-1:0] length;
	} leb_out_t;

endpackage

@@ src/leb_line_ram.sv @@
// Character store: one write port and one read port with registered read data.
module leb_line_ram
	import leb_pkg::*;
#(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/leb_edit_seq.sv @@
// Edit sequencer: cursor and fill state, shared index stepper and the shift/emit loops.
module leb_edit_seq
	import leb_pkg::*;
#(
	parameter int CAP = 63,
	parameter int IW  = 6,
	parameter int AW  = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  leb_cmd_t             in_cmd,
	input  logic [CHAR_W-1:0]    in_char,
	input  logic [MAX_OUT_W-1:0] emit_limit,
	input  logic                 out_ready,
	output leb_out_t             out_ctl,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [CHAR_W-1:0]    wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  logic [CHAR_W-1:0]    rd_data
);

	localparam logic [IW-1:0] CAP_W = IW'(CAP);

	leb_state_t        state_q, state_d;
	logic [IW-1:0]     idx_q, stop_q, cursor_q, fill_q;
	logic              dir_q;
	logic [CHAR_W-1:0] char_q;

	logic              accept;
	logic [IW-1:0]     nxt;
	logic              at_stop_nxt;
	logic [IW-1:0]     emit_len;
	logic              can_ins;
	logic              bs_ok;
	logic              del_ok;
	logic [IW-1:0]     del_cur;
	logic [IW-1:0]     fill_m1;

	assign accept = in_valid && in_ready;

	// Shared index stepper: one add or subtract and one compare.
	assign nxt         = dir_q ? (idx_q + IW'(1)) : (idx_q - IW'(1));
	assign at_stop_nxt = (nxt == stop_q);

	// Command decode helpers.
	assign fill_m1  = fill_q - IW'(1);
	assign can_ins  = (fill_q < CAP_W);
	assign bs_ok    = (cursor_q != '0);
	assign del_ok   = (cursor_q < fill_q);
	assign del_cur  = (in_cmd == CMD_BACKSPACE) ? (cursor_q - IW'(1)) : cursor_q;
	assign emit_len = (MAX_OUT_W'(fill_q) < emit_limit) ? fill_q : emit_limit[IW-1:0];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_INSERT: begin
							if (can_ins) begin
								state_d = (fill_q == cursor_q) ? ST_INS_PUT : ST_SH_RD;
							end
						end
						CMD_BACKSPACE, CMD_DELETE: begin
							if ((in_cmd == CMD_BACKSPACE) ? bs_ok : del_ok) begin
								state_d = (del_cur == fill_m1) ? ST_DEL_FIN : ST_SH_RD;
							end
						end
						CMD_ENTER: state_d = ST_EM_RD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: begin
				if (at_stop_nxt) begin
					state_d = dir_q ? ST_DEL_FIN : ST_INS_PUT;
				end else begin
					state_d = ST_SH_RD;
				end
			end
			ST_INS_PUT: state_d = ST_IDLE;
			ST_DEL_FIN: state_d = ST_IDLE;
			ST_EM_RD:   state_d = (idx_q == stop_q) ? ST_TERM : ST_EM_OUT;
			ST_EM_OUT: begin
				if (out_ready) begin
					state_d = ST_EM_RD;
				end
			end
			ST_TERM: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output logic: handshake, memory ports and output status.
	always_comb begin
		in_ready       = 1'b0;
		wr_en          = 1'b0;
		wr_addr        = idx_q[AW-1:0];
		wr_data        = rd_data;
		rd_en          = 1'b0;
		rd_addr        = nxt[AW-1:0];
		out_ctl.valid  = 1'b0;
		out_ctl.last   = 1'b0;
		out_ctl.length = '0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SH_RD: rd_en = 1'b1;
			ST_SH_WR: wr_en = 1'b1;
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = cursor_q[AW-1:0];
				wr_data = char_q;
			end
			ST_EM_RD: begin
				rd_en   = (idx_q != stop_q);
				rd_addr = idx_q[AW-1:0];
			end
			ST_EM_OUT: out_ctl.valid = 1'b1;
			ST_TERM: begin
				out_ctl.valid  = 1'b1;
				out_ctl.last   = 1'b1;
				out_ctl.length = MAX_OUT_W'(idx_q) + MAX_OUT_W'(1);
			end
			default: in_ready = 1'b0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor, fill count and loop registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			stop_q   <= '0;
			dir_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_INSERT: begin
								dir_q  <= 1'b0;
								idx_q  <= fill_q;
								stop_q <= cursor_q;
							end
							CMD_LEFT: begin
								if (bs_ok) begin
									cursor_q <= cursor_q - IW'(1);
								end
							end
							CMD_RIGHT: begin
								if (del_ok) begin
									cursor_q <= cursor_q + IW'(1);
								end
							end
							CMD_HOME: cursor_q <= '0;
							CMD_END:  cursor_q <= fill_q;
							CMD_BACKSPACE, CMD_DELETE: begin
								// The cursor only steps back when there is something to remove.
								if ((in_cmd == CMD_BACKSPACE) ? bs_ok : del_ok) begin
									cursor_q <= del_cur;
								end
								dir_q    <= 1'b1;
								idx_q    <= del_cur;
								stop_q   <= fill_m1;
							end
							CMD_ENTER: begin
								dir_q  <= 1'b1;
								idx_q  <= '0;
								stop_q <= emit_len;
							end
							default: dir_q <= dir_q;
						endcase
					end
				end
				ST_SH_WR: idx_q <= nxt;
				ST_INS_PUT: begin
					cursor_q <= cursor_q + IW'(1);
					fill_q   <= fill_q + IW'(1);
				end
				ST_DEL_FIN: fill_q <= fill_m1;
				ST_EM_OUT: begin
					if (out_ready) begin
						idx_q <= nxt;
					end
				end
				ST_TERM: begin
					if (out_ready) begin
						cursor_q <= '0;
						fill_q   <= '0;
					end
				end
				default: dir_q <= dir_q;
			endcase
		end
	end

	// Character held for the insert write.
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= in_char;
		end
	end

endmodule

@@ src/line_edit_buffer.sv @@
// Line edit buffer top level: stream ports, output room register and the sequencer.
//
// The block holds one editable text line of up to LINE_CAPACITY characters with a cursor and
// takes one decoded key command per input transaction (s_tuser holds the command, s_tdata the
// character for insert). A cursor move is done at acceptance. Every shift step goes
// through the character RAM as a registered read followed by a write: an insert moves
// the characters from the cursor on up by one and writes the new one; a delete or
// backspace moves the characters behind the removed one down by one and lowers the fill.
// Enter emits the stored line, cut to the output room less one, one character per output
// transaction, then a terminator with tlast set and the emitted length plus one. The input
// is not ready while a command is being worked on. The output room register may be written
// at any time through the cfg channel and is applied at the next enter.
module line_edit_buffer
	import leb_pkg::*;
#(
	parameter int LINE_CAPACITY = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] char_code
	input  logic [CMD_W-1:0]     s_tuser,   // [2:0] command
	// Emitted line stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [7:0] out_char, [14:8] line_length, [15] zero
	output logic                 m_tlast,   // is_last
	// Output room register write.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MAX_OUT_W-1:0] cfg_data
);

	localparam int IW = $clog2(LINE_CAPACITY + 1);
	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	logic [MAX_OUT_W-1:0] max_line_out_q;
	logic [MAX_OUT_W-1:0] emit_limit;
	leb_out_t             out_ctl;
	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [CHAR_W-1:0]    wr_data, rd_data;

	// Output room register; always ready for a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_out_q <= MAX_OUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_line_out_q <= cfg_data;
		end
	end

	// Character limit: room minus the terminator, zero room acts as one.
	assign emit_limit = (max_line_out_q == '0) ? '0 : (max_line_out_q - MAX_OUT_W'(1));

	leb_edit_seq #(
		.CAP (LINE_CAPACITY),
		.IW  (IW),
		.AW  (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (leb_cmd_t'(s_tuser)),
		.in_char    (s_tdata),
		.emit_limit (emit_limit),
		.out_ready  (m_tready),
		.out_ctl    (out_ctl),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	leb_line_ram #(
		.DEPTH (LINE_CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output packing: the character comes straight from the RAM read register.
	assign m_tvalid       = out_ctl.valid;
	assign m_tlast        = out_ctl.last;
	assign m_tdata[7:0]   = out_ctl.last ? '0 : rd_data;
	assign m_tdata[14:8]  = out_ctl.length;
	assign m_tdata[15]    = 1'b0;

endmodule

@@ dv/line_edit_buffer_checker.sv @@
// Checker for the line edit buffer: predicts the emitted lines and compares every output transaction.
`timescale 1ns / 100ps

module line_edit_buffer_checker
	import leb_pkg::*;
#(
	parameter int LINE_CAPACITY = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [CHAR_W-1:0]    s_tdata,    // [7:0] char_code
	input  logic [CMD_W-1:0]     s_tuser,    // [2:0] command
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,    // [7:0] out_char, [14:8] line_length, [15] zero
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [MAX_OUT_W-1:0] cfg_data,
	output int                   errors,
	output int                   waiting,
	output int                   keys_seen,
	output int                   chars_seen,
	output int                   lines_seen,
	output int                   lines_cut,
	output int                   full_drops,
	output int                   rooms_set
);

	// One expected output transaction of an emitted line.
	typedef struct packed {
		logic [CHAR_W-1:0]    ch;
		logic                 last;
		logic [MAX_OUT_W-1:0] len;
	} emit_t;

	emit_t emit_q[$];
	emit_t want;

	// Shadow copy of the line, the cursor and the output room.
	logic [CHAR_W-1:0]    text [LINE_CAPACITY];
	int unsigned          cur;
	int unsigned          fill;
	logic [MAX_OUT_W-1:0] room;

	int err_n, key_n, char_n, line_n, cut_n, drop_n, cfg_n;

	// Applies one key command to the shadow line and queues any emitted transactions.
	task automatic apply_key(input leb_cmd_t key, input logic [CHAR_W-1:0] ch);
		int unsigned room_chars;
		int unsigned emit_len;
		case (key)
			CMD_INSERT: begin
				if (fill >= LINE_CAPACITY) begin
					drop_n++;
				end else begin
					for (int unsigned i = fill; i > cur; i--)
						text[i] = text[i-1];
					text[cur] = ch;
					cur++;
					fill++;
				end
			end
			CMD_LEFT: begin
				if (cur > 0)
					cur--;
			end
			CMD_RIGHT: begin
				if (cur < fill)
					cur++;
			end
			CMD_HOME: begin
				cur = 0;
			end
			CMD_END: begin
				cur = fill;
			end
			CMD_BACKSPACE, CMD_DELETE: begin
				// Backspace steps back first, then both remove the character at the cursor.
				if (key == CMD_DELETE || cur > 0) begin
					if (key == CMD_BACKSPACE)
						cur--;
					if (cur < fill) begin
						for (int unsigned i = cur; i + 1 < fill; i++)
							text[i] = text[i+1];
						fill--;
					end
				end
			end
			default: begin
				// Enter: the room counts the terminator, and a room of zero acts like one.
				room_chars = (room == 0) ? 0 : room - 1;
				emit_len = (fill < room_chars) ? fill : room_chars;
				for (int unsigned k = 0; k < emit_len; k++)
					emit_q.push_back('{ch: text[k], last: 1'b0, len: '0});
				emit_q.push_back('{ch: '0, last: 1'b1, len: MAX_OUT_W'(emit_len + 1)});
				if (emit_len < fill)
					cut_n++;
				line_n++;
				cur = 0;
				fill = 0;
			end
		endcase
	endtask

	// Watch all three channels; results are checked before a new command is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q.delete();
			foreach (text[i])
				text[i] = '0;
			cur = 0;
			fill = 0;
			room = MAX_OUT_RESET;
			err_n = 0;
			key_n = 0;
			char_n = 0;
			line_n = 0;
			cut_n = 0;
			drop_n = 0;
			cfg_n = 0;
		end else begin
			// Output room write transaction.
			if (cfg_valid && cfg_ready) begin
				room = cfg_data;
				cfg_n++;
			end

			// Emitted line transaction.
			if (m_tvalid && m_tready) begin
				char_n++;
				if (emit_q.size() == 0) begin
					err_n++;
					$display("%0t: unexpected output transaction: char %02h last %0b length %0d",
						$time, m_tdata[7:0], m_tlast, m_tdata[14:8]);
				end else begin
					want = emit_q.pop_front();
					if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
						m_tdata[14:8] !== want.len || m_tdata[15] !== 1'b0) begin
						err_n++;
						$display(
							"%0t: mismatch: expected %02h/%0b/%0d/0, got %02h/%0b/%0d/%0b",
							$time, want.ch, want.last, want.len,
							m_tdata[7:0], m_tlast, m_tdata[14:8], m_tdata[15]);
					end
				end
			end

			// Key command transaction.
			if (s_tvalid && s_tready) begin
				key_n++;
				apply_key(leb_cmd_t'(s_tuser), s_tdata);
			end
		end
		errors     <= err_n;
		waiting    <= emit_q.size();
		keys_seen  <= key_n;
		chars_seen <= char_n;
		lines_seen <= line_n;
		lines_cut  <= cut_n;
		full_drops <= drop_n;
		rooms_set  <= cfg_n;
	end

endmodule

@@ dv/line_edit_buffer_test.sv @@
// Testbench top for the line edit buffer: clock, reset, key stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module line_edit_buffer_test;
	import leb_pkg::*;

	localparam int CAPACITY       = 63;
	// Longest quiet spell of the block: a full-line shift plus some margin.
	localparam int SETTLE         = 2 * CAPACITY + 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_KEYS     = 32;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [CHAR_W-1:0]    s_tdata   = '0;
	logic [CMD_W-1:0]     s_tuser   = CMD_INSERT;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [MAX_OUT_W-1:0] cfg_data  = '0;

	int errors, waiting, keys_seen, chars_seen, lines_seen, lines_cut, full_drops, rooms_set;

	int unsigned sent;
	int unsigned phase_start;
	int unsigned ready_hold = 0;
	int unsigned idle_cycles = 0;
	logic        steady = 1'b0;
	logic [MAX_OUT_W-1:0] room_plan [6];

	line_edit_buffer #(
		.LINE_CAPACITY(CAPACITY)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	line_edit_buffer_checker #(
		.LINE_CAPACITY(CAPACITY)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.waiting   (waiting),
		.keys_seen (keys_seen),
		.chars_seen(chars_seen),
		.lines_seen(lines_seen),
		.lines_cut (lines_cut),
		.full_drops(full_drops),
		.rooms_set (rooms_set)
	);

	// 4 ns clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Output side: runs of ready broken by stalls of random length.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
			ready_hold = $urandom_range(0, 24);
		end else begin
			m_tready <= 1'b0;
			ready_hold = pick_gap();
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sends one key command and then idles for a random gap unless the line runs steady.
	task automatic send_key(input leb_cmd_t key, input logic [CHAR_W-1:0] ch);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= key;
		s_tdata  <= ch;
		do @(posedge clk); while (!s_tready);
		sent++;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lets the emitted line drain and the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the output room once the block is idle.
	task automatic set_room(input logic [MAX_OUT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// A line of random edits, mostly typing, closed by enter.
	task automatic edit_line(input int unsigned steps);
		steady = ($urandom_range(0, 3) == 0);
		for (int unsigned n = 0; n < steps; n++) begin
			if ($urandom_range(0, 99) < 60)
				send_key(CMD_INSERT, CHAR_W'($urandom_range(0, 255)));
			else
				send_key(leb_cmd_t'($urandom_range(1, 6)), CHAR_W'($urandom));
		end
		send_key(CMD_ENTER, CHAR_W'($urandom));
	endtask

	// Types past the capacity with cursor moves mixed in, so the last inserts are dropped.
	task automatic fill_line();
		int unsigned typed;
		steady = ($urandom_range(0, 1) == 0);
		typed = 0;
		while (typed < CAPACITY + 3) begin
			if ($urandom_range(0, 7) == 0) begin
				send_key(leb_cmd_t'($urandom_range(1, 4)), CHAR_W'($urandom));
			end else begin
				send_key(CMD_INSERT, CHAR_W'($urandom_range(0, 255)));
				typed++;
			end
		end
		send_key(CMD_ENTER, CHAR_W'($urandom));
	endtask

	// Stimulus.
	initial begin
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty line, edges of the cursor, control and extreme codes, mid-line edits.
		steady = 1'b0;
		send_key(CMD_ENTER, 8'hA5);
		send_key(CMD_LEFT, 8'h00);
		send_key(CMD_BACKSPACE, 8'h00);
		send_key(CMD_RIGHT, 8'hFF);
		send_key(CMD_DELETE, 8'hFF);
		send_key(CMD_INSERT, 8'h00);
		send_key(CMD_INSERT, 8'hFF);
		send_key(CMD_INSERT, 8'h7F);
		send_key(CMD_INSERT, 8'h08);
		send_key(CMD_INSERT, 8'h09);
		send_key(CMD_INSERT, 8'h0D);
		send_key(CMD_INSERT, 8'h0A);
		send_key(CMD_HOME, 8'h00);
		send_key(CMD_DELETE, 8'h00);
		send_key(CMD_END, 8'h00);
		send_key(CMD_RIGHT, 8'h00);
		send_key(CMD_DELETE, 8'h00);
		send_key(CMD_LEFT, 8'h00);
		send_key(CMD_LEFT, 8'h00);
		send_key(CMD_BACKSPACE, 8'h00);
		send_key(CMD_RIGHT, 8'h00);
		send_key(CMD_INSERT, 8'h55);
		send_key(CMD_ENTER, 8'h00);

		// Random phases over several output room settings, the extremes among them.
		room_plan = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd0, MAX_OUT_RESET};
		room_plan[4] = MAX_OUT_W'($urandom_range(2, 63));
		foreach (room_plan[p]) begin
			set_room(room_plan[p]);
			phase_start = sent;
			if (room_plan[p] == 7'd127 || room_plan[p] == 7'd1)
				fill_line();
			while (sent - phase_start < PHASE_KEYS)
				edit_line($urandom_range(0, 20));
		end

		drain();
		$display("Sent %0d key commands: %0d lines entered, %0d cut short by the output room,",
			keys_seen, lines_seen, lines_cut);
		$display("%0d inserts dropped on a full line, %0d output transactions, %0d room writes.",
			full_drops, chars_seen, rooms_set);
		if (errors == 0 && waiting == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ line_edit_buffer.f @@
src/leb_pkg.sv
src/leb_line_ram.sv
src/leb_edit_seq.sv
src/line_edit_buffer.sv
dv/line_edit_buffer_checker.sv
dv/line_edit_buffer_test.sv
